// ===== rtl/maf_pkg.sv =====
// Package for the moving-average filter: field widths, codes and the
// command type passed from the front end to the back end. No dependencies.
package maf_pkg;

  // Field widths of the stream and configuration ports
  localparam int unsigned SampleW  = 16;
  localparam int unsigned AvgW     = 16;
  localparam int unsigned WindowW  = 5;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 1;

  // Reset value of window_size and depth of the command queue
  localparam int unsigned WindowReset = 16;
  localparam int unsigned QueueDepth  = 2;

  // Item kinds carried in tuser
  localparam logic MODE_SAMPLE  = 1'b0;
  localparam logic MODE_RESTART = 1'b1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_WINDOW_SIZE = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_FILL_VALUE  = 1'b1;

  // One classified item waiting for the back end
  typedef struct packed {
    logic               restart;
    logic [SampleW-1:0] sample;
  } cmd_t;

endpackage

// ===== rtl/maf_front.sv =====
// Front end of the moving-average filter: accepts stream items, classifies
// them and holds them in a short command queue. Depends on maf_pkg.
module maf_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [maf_pkg::SampleW-1:0] s_axis_tdata,
  input  logic [0:0]                 s_axis_tuser,
  output logic                       cmd_valid_o,
  input  logic                       cmd_ready_i,
  output maf_pkg::cmd_t              cmd_o
);

  localparam int unsigned PtrW = (maf_pkg::QueueDepth > 1) ? $clog2(maf_pkg::QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(maf_pkg::QueueDepth + 1);

  maf_pkg::cmd_t          queue_q [maf_pkg::QueueDepth];
  logic [PtrW-1:0]        wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]        rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]        count_q, count_d;
  logic                   push, pop;
  maf_pkg::cmd_t          cmd_in;

  // Classify the incoming item
  always_comb begin
    cmd_in.restart = (s_axis_tuser[0] == maf_pkg::MODE_RESTART);
    cmd_in.sample  = s_axis_tdata;
  end

  assign s_axis_tready = (count_q != CntW'(maf_pkg::QueueDepth));
  assign push          = s_axis_tvalid & s_axis_tready;
  assign cmd_valid_o   = (count_q != '0);
  assign pop           = cmd_valid_o & cmd_ready_i;
  assign cmd_o         = queue_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(maf_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(maf_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the transfer into the queue
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

// ===== rtl/maf_div.sv =====
// Restoring divider, one quotient bit per cycle, for the moving-average
// filter's window mean. No package dependencies.
module maf_div #(
  parameter int unsigned DividendW = 20,
  parameter int unsigned DivisorW  = 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DividendW-1:0] dividend_i,
  input  logic [DivisorW-1:0]  divisor_i,
  output logic                 done_o,
  output logic [DividendW-1:0] quotient_o
);

  localparam int unsigned CntW = $clog2(DividendW + 1);

  logic [DividendW-1:0] quo_q;
  logic [DivisorW-1:0]  rem_q;
  logic [DivisorW-1:0]  div_q;
  logic [CntW-1:0]      cnt_q;
  logic                 busy_q, done_q;
  logic [DivisorW:0]    trial, diff;
  logic                 qbit;

  // Shift in the next dividend bit and try a subtract
  always_comb begin
    trial = {rem_q, quo_q[DividendW-1]};
    diff  = trial - {1'b0, div_q};
    qbit  = ~diff[DivisorW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      div_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CntW'(DividendW);
      quo_q  <= dividend_i;
      rem_q  <= '0;
      div_q  <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DividendW-2:0], qbit};
      rem_q <= qbit ? diff[DivisorW-1:0] : trial[DivisorW-1:0];
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== rtl/maf_back.sv =====
// Back end of the moving-average filter: sample ring, running sum, window
// mean through maf_div and the output register. Depends on maf_pkg, maf_div.
module maf_back #(
  parameter int unsigned MAX_TAPS    = 16,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cmd_valid_i,
  output logic                         cmd_ready_o,
  input  maf_pkg::cmd_t                cmd_i,
  input  logic [maf_pkg::WindowW-1:0]  window_size_i,
  input  logic [maf_pkg::SampleW-1:0]  fill_value_i,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [maf_pkg::AvgW-1:0]     m_axis_tdata
);

  localparam int unsigned RingW   = SAMPLE_BITS;
  localparam int unsigned WinW    = $clog2(MAX_TAPS + 1);
  localparam int unsigned AddrW   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int unsigned SumW    = RingW + WinW;
  localparam int unsigned ResetWin = (maf_pkg::WindowReset > MAX_TAPS) ? MAX_TAPS :
                                     maf_pkg::WindowReset;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_START,
    ST_WAIT
  } state_e;

  state_e              state_q;
  logic [WinW-1:0]     win_q;
  logic [AddrW-1:0]    pos_q;
  logic [SumW-1:0]     sum_q;
  logic [RingW-1:0]    fill_q;
  logic [RingW-1:0]    sample_q;
  logic [MAX_TAPS-1:0] valid_q;
  logic                out_valid_q;
  logic [maf_pkg::AvgW-1:0] out_data_q;

  logic [RingW-1:0]    ring_mem [MAX_TAPS];
  logic [RingW-1:0]    rdata_q;
  logic                ring_we;

  logic [RingW-1:0]    sample_m, fill_m, old_val;
  logic [WinW-1:0]     win_new;
  logic [WinW-1:0]     pos_next;
  logic [SumW-1:0]     sum_upd;
  logic [SumW-1:0]     fill_prod;
  logic                div_done;
  logic [SumW-1:0]     div_quo;
  logic                out_free;
  logic                out_load;
  logic [maf_pkg::SampleW+RingW-1:0] sample_ext, fill_ext;
  logic [maf_pkg::WindowW+WinW-1:0]  ws_ext;
  logic [SumW+maf_pkg::AvgW-1:0]     quo_ext;

  // Mask sample and fill value to the ring width
  always_comb begin
    sample_ext = {{RingW{1'b0}}, cmd_i.sample};
    fill_ext   = {{RingW{1'b0}}, fill_value_i};
    sample_m   = sample_ext[RingW-1:0];
    fill_m     = fill_ext[RingW-1:0];
  end

  // Clamp the configured window to 1..MAX_TAPS
  always_comb begin
    ws_ext = {{WinW{1'b0}}, window_size_i};
    if (window_size_i == '0) begin
      win_new = WinW'(1);
    end else if (32'(window_size_i) > MAX_TAPS) begin
      win_new = WinW'(MAX_TAPS);
    end else begin
      win_new = ws_ext[WinW-1:0];
    end
  end

  assign fill_prod = SumW'(fill_m) * SumW'(win_new);

  // Oldest entry, new running sum and next write position
  always_comb begin
    old_val  = valid_q[pos_q] ? rdata_q : fill_q;
    sum_upd  = sum_q - SumW'(old_val) + SumW'(sample_q);
    pos_next = WinW'(pos_q) + 1'b1;
  end

  assign cmd_ready_o = (state_q == ST_IDLE);
  assign out_free    = ~out_valid_q | m_axis_tready;
  assign out_load    = (state_q == ST_WAIT) && div_done && out_free;
  assign ring_we     = (state_q == ST_READ);

  // Sequencer, running state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      win_q       <= WinW'(ResetWin);
      pos_q       <= '0;
      sum_q       <= '0;
      fill_q      <= '0;
      sample_q    <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      // Load a finished mean, or free the output register after a transfer
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_data_q  <= quo_ext[maf_pkg::AvgW-1:0];
      end else if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i) begin
            if (cmd_i.restart) begin
              win_q   <= win_new;
              fill_q  <= fill_m;
              sum_q   <= fill_prod;
              pos_q   <= '0;
              valid_q <= '0;
              state_q <= ST_START;
            end else begin
              sample_q <= sample_m;
              state_q  <= ST_READ;
            end
          end
        end
        ST_READ: begin
          sum_q          <= sum_upd;
          valid_q[pos_q] <= 1'b1;
          pos_q          <= (pos_next == win_q) ? '0 : pos_next[AddrW-1:0];
          state_q        <= ST_START;
        end
        ST_START: begin
          state_q <= ST_WAIT;
        end
        ST_WAIT: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Ring memory: read at the write position, write the new sample
  always_ff @(posedge clk_i) begin
    rdata_q <= ring_mem[pos_q];
    if (ring_we) begin
      ring_mem[pos_q] <= sample_q;
    end
  end

  maf_div #(
    .DividendW (SumW),
    .DivisorW  (WinW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == ST_START),
    .dividend_i (sum_q),
    .divisor_i  (win_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign quo_ext       = {{maf_pkg::AvgW{1'b0}}, div_quo};
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== rtl/moving_average_filter.sv =====
// Moving-average filter, top level: configuration registers, front end and
// back end. Depends on maf_pkg, maf_front, maf_back.
//
// Boxcar mean over the last window_size samples held in a ring of MAX_TAPS
// entries. Each input item gives one result: a sample item (tuser 0) replaces
// the oldest entry; a restart item (tuser 1) fills the window with fill_value,
// latches window_size (0 counts as 1, values above MAX_TAPS saturate) and
// resets the write position. Writes to window_size only take effect at the
// next restart. The mean comes from a one-bit-per-cycle divider, which sets
// the rate: the back end takes a new item only once the last result has been
// loaded into the output register. A restart item skips the ring update. A
// two-entry command queue keeps accepting items, while it has room, as the
// back end works or a result waits on the output. The ring needs no clearing pass after reset.
module moving_average_filter #(
  parameter int unsigned MAX_TAPS    = 16,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [maf_pkg::SampleW-1:0]   s_axis_tdata,   // [15:0] sample
  input  logic [0:0]                    s_axis_tuser,   // [0] mode
  // Output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [maf_pkg::AvgW-1:0]      m_axis_tdata,   // [15:0] average
  // Configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [maf_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [maf_pkg::CfgDataW-1:0]  cfg_data_i
);

  logic [maf_pkg::WindowW-1:0] window_size_q;
  logic [maf_pkg::SampleW-1:0] fill_value_q;
  logic                        cmd_valid, cmd_ready;
  maf_pkg::cmd_t               cmd;

  assign cfg_ready_o = 1'b1;

  // Decode configuration transfers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q <= maf_pkg::WindowW'(maf_pkg::WindowReset);
      fill_value_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        maf_pkg::REG_WINDOW_SIZE: window_size_q <= cfg_data_i[maf_pkg::WindowW-1:0];
        maf_pkg::REG_FILL_VALUE:  fill_value_q  <= cfg_data_i[maf_pkg::SampleW-1:0];
        default: ;
      endcase
    end
  end

  maf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cmd_valid_o   (cmd_valid),
    .cmd_ready_i   (cmd_ready),
    .cmd_o         (cmd)
  );

  maf_back #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_ready_o   (cmd_ready),
    .cmd_i         (cmd),
    .window_size_i (window_size_q),
    .fill_value_i  (fill_value_q),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// ===== rtl/maf_checker.sv =====
// Port-level checks for the moving-average filter, bound to the top level.
// Depends on maf_pkg.
module maf_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tvalid,
  input logic                      s_axis_tready,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [maf_pkg::AvgW-1:0]  m_axis_tdata
);

  // Queue entries plus one item in the back end plus the output register
  localparam int unsigned MaxPending = maf_pkg::QueueDepth + 2;
  localparam int unsigned PendW      = $clog2(MaxPending + 2);

  logic [PendW-1:0] pending_q;
  logic             in_xfer, out_xfer;

  assign in_xfer  = s_axis_tvalid & s_axis_tready;
  assign out_xfer = m_axis_tvalid & m_axis_tready;

  // Track items accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      case ({in_xfer, out_xfer})
        2'b10:   pending_q <= pending_q + 1'b1;
        2'b01:   pending_q <= pending_q - 1'b1;
        default: pending_q <= pending_q;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed or dropped while stalled");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer |-> pending_q != '0)
    else $error("result delivered with no item outstanding");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= PendW'(MaxPending))
    else $error("more items outstanding than the block can hold");

  a_reset_idle: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result valid when leaving reset");

endmodule

bind moving_average_filter maf_checker u_maf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== bench/moving_average_filter_tb.sv =====
// Self-checking bench for moving_average_filter: drives sample and restart
// transfers and register writes, and predicts every average in a scoreboard.
// Depends on maf_pkg and the moving_average_filter RTL.
`timescale 1ns / 1ps

module moving_average_filter_tb;

  localparam int unsigned RingDepth  = 16;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned SettleCyc  = 30;
  localparam int unsigned SegItems   = 144;

  // Running-sum model of the filter plus the queue of averages still owed
  class avg_scoreboard;
    logic [maf_pkg::SampleW-1:0] ring [RingDepth];
    int unsigned                 wr_pos;
    int unsigned                 run_sum;
    int unsigned                 taps;
    logic [maf_pkg::WindowW-1:0] win_reg;
    logic [maf_pkg::SampleW-1:0] fill_reg;
    logic [maf_pkg::AvgW-1:0]    avg_queue [$];
    int unsigned                 errors;

    function new();
      foreach (ring[i]) ring[i] = '0;
      wr_pos   = 0;
      run_sum  = 0;
      win_reg  = maf_pkg::WindowW'(maf_pkg::WindowReset);
      fill_reg = '0;
      taps     = RingDepth;
      errors   = 0;
    endfunction

    function int unsigned pending();
      return avg_queue.size();
    endfunction

    function void write_reg(logic [maf_pkg::CfgIdxW-1:0] idx,
                            logic [maf_pkg::CfgDataW-1:0] data);
      if (idx == maf_pkg::REG_WINDOW_SIZE) win_reg = data[maf_pkg::WindowW-1:0];
      else if (idx == maf_pkg::REG_FILL_VALUE) fill_reg = data[maf_pkg::SampleW-1:0];
    endfunction

    // Update the ring for one accepted input and queue its average
    function void note_item(logic mode, logic [maf_pkg::SampleW-1:0] sample);
      int unsigned p;
      if (mode == maf_pkg::MODE_RESTART) begin
        // Latch the window here: zero counts as one, above the depth saturates
        if (win_reg == 0) taps = 1;
        else if (win_reg > RingDepth) taps = RingDepth;
        else taps = win_reg;
        for (int i = 0; i < taps; i++) ring[i] = fill_reg;
        run_sum = fill_reg * taps;
        wr_pos  = 0;
      end else begin
        p = (wr_pos >= taps) ? 0 : wr_pos;
        run_sum = run_sum - ring[p] + sample;
        ring[p] = sample;
        p++;
        wr_pos = (p >= taps) ? 0 : p;
      end
      avg_queue.push_back(maf_pkg::AvgW'(run_sum / taps));
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    // Compare one output transfer with the oldest expected average
    task check_average(logic [maf_pkg::AvgW-1:0] got);
      logic [maf_pkg::AvgW-1:0] want;
      if (avg_queue.size() == 0) begin
        report_mismatch($sformatf("average %h with nothing expected", got));
      end else begin
        want = avg_queue.pop_front();
        if (got !== want)
          report_mismatch($sformatf("average %h, expected %h", got, want));
      end
    endtask
  endclass

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [maf_pkg::SampleW-1:0]  s_axis_tdata = '0;
  logic [0:0]                   s_axis_tuser = '0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [maf_pkg::AvgW-1:0]     m_axis_tdata;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [maf_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [maf_pkg::CfgDataW-1:0] cfg_data = '0;

  int unsigned   src_idle_pct  = 0;
  int unsigned   sink_stall_pct = 0;
  int unsigned   quiet_cycles = 0;
  avg_scoreboard sb = new();

  moving_average_filter dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [15:0] sample
    .s_axis_tuser  (s_axis_tuser),   // [0] mode
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [15:0] average
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  always #6 clk = ~clk;

  // Stall the output side at the current rate
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Observe transfers on all three channels
  always @(posedge clk) begin
    if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
    if (s_axis_tvalid && s_axis_tready) sb.note_item(s_axis_tuser[0], s_axis_tdata);
    if (m_axis_tvalid && m_axis_tready) sb.check_average(m_axis_tdata);
  end

  // Abort when no transfer of any kind happens for too long
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one item after a random gap and hold it until the transfer
  task automatic send_item(logic mode, logic [maf_pkg::SampleW-1:0] sample);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= sample;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Drop valid and wait for every owed average, then let the pipe settle
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SettleCyc) @(posedge clk);
  endtask

  task automatic write_reg(logic [maf_pkg::CfgIdxW-1:0] idx,
                           logic [maf_pkg::CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [maf_pkg::SampleW-1:0] pick_value();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return maf_pkg::SampleW'($urandom());
    endcase
  endfunction

  // Random window setting, extremes often; upper data bits are don't-care
  function automatic logic [maf_pkg::CfgDataW-1:0] pick_window();
    logic [4:0]                   win;
    logic [maf_pkg::CfgDataW-1:0] word;
    int unsigned                  corner [7] = '{0, 1, 2, 15, 16, 17, 31};
    if ($urandom_range(1) == 0) win = 5'(corner[$urandom_range(6)]);
    else win = 5'($urandom_range(31));
    word = maf_pkg::CfgDataW'($urandom());
    word[maf_pkg::WindowW-1:0] = win;
    return word;
  endfunction

  initial begin
    int unsigned stall_mode [4][2];
    stall_mode = '{'{0, 0}, '{75, 0}, '{0, 75}, '{21, 21}};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset state: window of sixteen over a zero ring
    send_item(maf_pkg::MODE_SAMPLE, 16'hFFFF);
    send_item(maf_pkg::MODE_SAMPLE, 16'h0000);
    send_item(maf_pkg::MODE_SAMPLE, 16'h8001);
    send_item(maf_pkg::MODE_RESTART, 16'hFFFF);
    drain_results();

    // Zero window with upper data bits set; the old window holds until restart
    write_reg(maf_pkg::REG_WINDOW_SIZE, 16'hFFE0);
    write_reg(maf_pkg::REG_FILL_VALUE, 16'hFFFF);
    send_item(maf_pkg::MODE_SAMPLE, 16'h1234);
    send_item(maf_pkg::MODE_RESTART, 16'h5555);
    send_item(maf_pkg::MODE_SAMPLE, 16'h0000);
    send_item(maf_pkg::MODE_SAMPLE, 16'hFFFF);
    drain_results();

    // Window above the ring depth saturates
    write_reg(maf_pkg::REG_WINDOW_SIZE, 16'h001F);
    write_reg(maf_pkg::REG_FILL_VALUE, 16'hAAAA);
    send_item(maf_pkg::MODE_RESTART, 16'h0000);
    repeat (4) send_item(maf_pkg::MODE_SAMPLE, 16'hFFFF);
    drain_results();

    // Full window of maximum values: largest running sum
    write_reg(maf_pkg::REG_WINDOW_SIZE, 16'h0010);
    write_reg(maf_pkg::REG_FILL_VALUE, 16'hFFFF);
    send_item(maf_pkg::MODE_RESTART, 16'hAAAA);
    repeat (3) send_item(maf_pkg::MODE_SAMPLE, 16'hFFFF);
    send_item(maf_pkg::MODE_SAMPLE, 16'h0000);
    send_item(maf_pkg::MODE_RESTART, 16'h0000);
    drain_results();

    // Random segments under each stall mix, new settings per segment
    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct   = stall_mode[ph][0];
      sink_stall_pct = stall_mode[ph][1];
      for (int seg = 0; seg < 3; seg++) begin
        write_reg(maf_pkg::REG_WINDOW_SIZE, pick_window());
        write_reg(maf_pkg::REG_FILL_VALUE, pick_value());
        // Usually restart first; otherwise keep the previously latched window
        if ($urandom_range(9) < 7)
          send_item(maf_pkg::MODE_RESTART, maf_pkg::SampleW'($urandom()));
        for (int n = 0; n < SegItems; n++) begin
          if ($urandom_range(19) == 0)
            send_item(maf_pkg::MODE_RESTART, maf_pkg::SampleW'($urandom()));
          else send_item(maf_pkg::MODE_SAMPLE, pick_value());
          if ($urandom_range(199) == 0) drain_results();
        end
        drain_results();
      end
    end

    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d averages never arrived", sb.pending()));
    if (sb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
